// ===== rtl/hkr_pkg.sv =====
// hkr_pkg: shared types and constants for the keyboard report keeper
// no dependencies

package hkr_pkg;

  localparam int unsigned REPORT_SLOTS = 6;

  localparam logic [7:0] MOD_PREFIX   = 8'h80;
  localparam logic [7:0] USAGE_PREFIX = 8'h40;
  localparam logic [7:0] EMPTY_CODE   = 8'h00;

  localparam logic OP_PRESS   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } hkr_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } hkr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
  } hkr_sts_t;

  typedef struct packed {
    logic [7:0]                   modifier_bits;
    logic [REPORT_SLOTS-1:0][7:0] slot_codes;
  } hkr_report_t;

endpackage

// ===== rtl/hkr_if.sv =====
// hkr_in_if / hkr_out_if: valid-ready channels for key events and reports
// no dependencies

interface hkr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] key_code;

  modport source (output valid, output op, output key_code, input ready);
  modport sink   (input valid, input op, input key_code, output ready);
endinterface

interface hkr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_bits;
  logic [7:0] slot0_code;
  logic [7:0] slot1_code;
  logic [7:0] slot2_code;
  logic [7:0] slot3_code;
  logic [7:0] slot4_code;
  logic [7:0] slot5_code;

  modport source (output valid, output modifier_bits, output slot0_code,
                  output slot1_code, output slot2_code, output slot3_code,
                  output slot4_code, output slot5_code, input ready);
  modport sink   (input valid, input modifier_bits, input slot0_code,
                  input slot1_code, input slot2_code, input slot3_code,
                  input slot4_code, input slot5_code, output ready);
endinterface

// ===== rtl/hkr_ctrl.sv =====
// hkr_ctrl: sequencer for accept, slot scan, commit and report handoff
// depends on hkr_pkg

module hkr_ctrl
  import hkr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  hkr_sts_t sts_i,
  output hkr_cmd_t cmd_o
);

  hkr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hkr_dp.sv =====
// hkr_dp: modifier byte, key slots, one-slot-a-cycle search and update
// depends on hkr_pkg

module hkr_dp
  import hkr_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hkr_cmd_t    cmd_i,
  input  logic        op_i,
  input  logic [15:0] key_code_i,
  output hkr_sts_t    sts_o,
  output hkr_report_t report_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  logic [7:0]            mods_q, mods_d;
  logic [7:0]            slots_q [SLOT_COUNT];
  logic [7:0]            slots_d [SLOT_COUNT];
  logic                  op_q;
  logic [15:0]           code_q;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  found_q, found_d, empty_q, empty_d;
  logic [IdxW-1:0]       found_idx_q, found_idx_d, empty_idx_q, empty_idx_d;
  logic [7:0]            low, prefix, cur;

  assign low    = code_q[7:0];
  assign prefix = code_q[15:8];
  assign cur    = slots_q[idx_q];

  assign sts_o.scan_last = (idx_q == LastIdx);

  always_comb begin
    mods_d      = mods_q;
    slots_d     = slots_q;
    idx_d       = idx_q;
    found_d     = found_q;
    empty_d     = empty_q;
    found_idx_d = found_idx_q;
    empty_idx_d = empty_idx_q;
    if (cmd_i.load) begin
      idx_d   = '0;
      found_d = 1'b0;
      empty_d = 1'b0;
    end
    if (cmd_i.step) begin
      // remember the first matching slot and the first empty one
      if (!found_q && cur == low) begin
        found_d     = 1'b1;
        found_idx_d = idx_q;
      end
      if (!empty_q && cur == EMPTY_CODE) begin
        empty_d     = 1'b1;
        empty_idx_d = idx_q;
      end
      if (!sts_o.scan_last) begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (cmd_i.commit) begin
      if (prefix == MOD_PREFIX) begin
        if (op_q == OP_RELEASE) begin
          mods_d = mods_q & ~low;
        end else begin
          mods_d = mods_q | low;
        end
      end else if (prefix == USAGE_PREFIX && low != EMPTY_CODE) begin
        if (op_q == OP_RELEASE) begin
          if (found_q) begin
            slots_d[found_idx_q] = EMPTY_CODE;
          end
        end else if (!found_q && empty_q) begin
          slots_d[empty_idx_q] = low;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots_q[i] <= EMPTY_CODE;
      end
      idx_q   <= '0;
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      mods_q  <= mods_d;
      slots_q <= slots_d;
      idx_q   <= idx_d;
      found_q <= found_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      code_q <= key_code_i;
    end
    found_idx_q <= found_idx_d;
    empty_idx_q <= empty_idx_d;
  end

  assign report_o.modifier_bits = mods_q;

  for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_report
    if (j < SLOT_COUNT) begin : g_slot
      assign report_o.slot_codes[j] = slots_q[j];
    end else begin : g_none
      assign report_o.slot_codes[j] = EMPTY_CODE;
    end
  end

endmodule

// ===== rtl/hid_keyboard_report_slots.sv =====
// an accepted word is registered, then the datapath searches one slot a cycle (SCAN),
// updates the modifiers or a slot (COMMIT) and raises report valid (OUT); a new word
// is taken only after the report is taken, so a stalled report side holds the input
// reset: asynchronous, active low; clears the modifiers and empties all slots
// hid_keyboard_report_slots: top level, joins controller, datapath and channels
// depends on hkr_pkg, hkr_if, hkr_ctrl, hkr_dp

module hid_keyboard_report_slots
  import hkr_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hkr_in_if.sink    in_i,
  hkr_out_if.source out_o
);

  hkr_cmd_t    cmd;
  hkr_sts_t    sts;
  hkr_report_t report;

  hkr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hkr_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (in_i.op),
    .key_code_i (in_i.key_code),
    .sts_o      (sts),
    .report_o   (report)
  );

  assign out_o.modifier_bits = report.modifier_bits;
  assign out_o.slot0_code    = report.slot_codes[0];
  assign out_o.slot1_code    = report.slot_codes[1];
  assign out_o.slot2_code    = report.slot_codes[2];
  assign out_o.slot3_code    = report.slot_codes[3];
  assign out_o.slot4_code    = report.slot_codes[4];
  assign out_o.slot5_code    = report.slot_codes[5];

endmodule

// ===== dv/testbench.sv =====
// testbench: checks the keyboard report keeper against its own model of the report
// directed key events from a table, then random events with idling on both sides
// depends on hkr_pkg, hkr_if and hid_keyboard_report_slots

module testbench;
  import hkr_pkg::*;

  localparam int unsigned SLOTS        = 6;
  localparam int          RANDOM_WORDS = 1080;
  localparam int          QUIET_TAIL   = 150;
  localparam int          HOLD_AT      = 400;
  localparam int          HOLD_CYCLES  = 120;
  localparam int          DRAIN_LIMIT  = 2000;
  localparam int          NUM_ROWS     = 24;

  typedef struct {
    logic        op;
    logic [15:0] code;
    bit          typed;
    hkr_report_t want;
  } key_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hkr_in_if  key_ch ();
  hkr_out_if report_ch ();

  hid_keyboard_report_slots #(
    .SLOT_COUNT(SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (key_ch),
    .out_o (report_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // own copy of the report state
  logic [7:0]  held_mods;
  logic [7:0]  key_slots [SLOTS];
  hkr_report_t expected_reports [$];

  int  errors;
  int  words_sent;
  int  reports_checked;
  int  dropped_presses;
  int  repeat_presses;
  int  stray_releases;
  bit  hold_off;
  bit  quiet;
  int  stall_left;
  int  run_left;

  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

  function automatic hkr_report_t make_report(input logic [7:0] mods, input logic [7:0] s0,
                                              input logic [7:0] s1, input logic [7:0] s2,
                                              input logic [7:0] s3, input logic [7:0] s4,
                                              input logic [7:0] s5);
    hkr_report_t rep;
    rep.modifier_bits = mods;
    rep.slot_codes[0] = s0;
    rep.slot_codes[1] = s1;
    rep.slot_codes[2] = s2;
    rep.slot_codes[3] = s3;
    rep.slot_codes[4] = s4;
    rep.slot_codes[5] = s5;
    return rep;
  endfunction

  // applies one key event to the local state and returns the report that follows
  function automatic hkr_report_t apply_key_event(input logic op, input logic [15:0] code);
    logic [7:0]  prefix;
    logic [7:0]  low;
    int          hit;
    int          free;
    int          i;
    hkr_report_t rep;
    prefix = code[15:8];
    low    = code[7:0];
    if (prefix == MOD_PREFIX) begin
      if (op == OP_RELEASE) held_mods = held_mods & ~low;
      else held_mods = held_mods | low;
    end else if (prefix == USAGE_PREFIX && low != EMPTY_CODE) begin
      hit  = -1;
      free = -1;
      for (i = 0; i < SLOTS; i++) begin
        if (hit < 0 && key_slots[i] == low) hit = i;
        if (free < 0 && key_slots[i] == EMPTY_CODE) free = i;
      end
      if (op == OP_RELEASE) begin
        if (hit >= 0) key_slots[hit] = EMPTY_CODE;
        else stray_releases++;
      end else if (hit >= 0) begin
        repeat_presses++;
      end else if (free >= 0) begin
        key_slots[free] = low;
      end else begin
        dropped_presses++;
      end
    end
    rep.modifier_bits = held_mods;
    for (i = 0; i < REPORT_SLOTS; i++)
      rep.slot_codes[i] = (i < SLOTS) ? key_slots[i] : EMPTY_CODE;
    return rep;
  endfunction

  // offers one word and waits for it to be taken; valid is left high
  task automatic send_word(input logic op, input logic [15:0] code, input bit typed,
                           input hkr_report_t want);
    hkr_report_t predicted;
    int          gap;
    gap = 0;
    if (!quiet && !hold_off && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_ch.valid    <= 1'b1;
    key_ch.op       <= op;
    key_ch.key_code <= code;
    do @(posedge clk_i); while (!key_ch.ready);
    predicted = apply_key_event(op, code);
    expected_reports.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // random key event: mostly usage codes from a small pool so that slots fill
  task automatic random_event(input int press_pct, output logic op,
                              output logic [15:0] code, output bit counted);
    int pick;
    pick    = $urandom_range(0, 99);
    op      = ($urandom_range(0, 99) < press_pct) ? OP_PRESS : OP_RELEASE;
    counted = 1'b1;
    if (pick < 62) begin
      code[15:8] = USAGE_PREFIX;
      case ($urandom_range(0, 19))
        0:       code[7:0] = EMPTY_CODE;
        1, 2:    code[7:0] = 8'($urandom_range(0, 255));
        default: code[7:0] = 8'($urandom_range(1, 10));
      endcase
    end else if (pick < 88) begin
      code[15:8] = MOD_PREFIX;
      if ($urandom_range(0, 1)) code[7:0] = 8'h01 << $urandom_range(0, 7);
      else code[7:0] = 8'($urandom_range(0, 255));
    end else begin
      code    = 16'($urandom_range(0, 65535));
      counted = (code[15:8] == MOD_PREFIX || code[15:8] == USAGE_PREFIX);
    end
  endtask

  task automatic check_report(input hkr_report_t want);
    if (report_ch.modifier_bits !== want.modifier_bits) begin
      $error("modifier_bits: expected %02h, got %02h", want.modifier_bits,
             report_ch.modifier_bits);
      errors++;
    end
    if (report_ch.slot0_code !== want.slot_codes[0]) begin
      $error("slot0_code: expected %02h, got %02h", want.slot_codes[0], report_ch.slot0_code);
      errors++;
    end
    if (report_ch.slot1_code !== want.slot_codes[1]) begin
      $error("slot1_code: expected %02h, got %02h", want.slot_codes[1], report_ch.slot1_code);
      errors++;
    end
    if (report_ch.slot2_code !== want.slot_codes[2]) begin
      $error("slot2_code: expected %02h, got %02h", want.slot_codes[2], report_ch.slot2_code);
      errors++;
    end
    if (report_ch.slot3_code !== want.slot_codes[3]) begin
      $error("slot3_code: expected %02h, got %02h", want.slot_codes[3], report_ch.slot3_code);
      errors++;
    end
    if (report_ch.slot4_code !== want.slot_codes[4]) begin
      $error("slot4_code: expected %02h, got %02h", want.slot_codes[4], report_ch.slot4_code);
      errors++;
    end
    if (report_ch.slot5_code !== want.slot_codes[5]) begin
      $error("slot5_code: expected %02h, got %02h", want.slot_codes[5], report_ch.slot5_code);
      errors++;
    end
  endtask

  // report side: check each accepted word, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_ch.ready <= 1'b0;
      stall_left      <= 0;
      run_left        <= 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("report word with nothing expected");
          errors++;
        end else begin
          check_report(expected_reports.pop_front());
          reports_checked++;
        end
      end
      if (hold_off) begin
        report_ch.ready <= 1'b0;
      end else if (quiet) begin
        report_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        report_ch.ready <= 1'b0;
        stall_left      <= stall_left - 1;
      end else if (run_left > 0) begin
        report_ch.ready <= 1'b1;
        run_left        <= run_left - 1;
      end else begin
        report_ch.ready <= 1'b0;
        stall_left      <= $urandom_range(0, 6);
        run_left        <= $urandom_range(0, 24);
      end
    end
  end

  // long hold-off on the report side so the block backs up into its input
  initial begin
    hold_off = 1'b0;
    wait (words_sent >= HOLD_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    key_row_t     plan [NUM_ROWS];
    hkr_report_t  none;
    logic         op;
    logic [15:0]  code;
    bit           counted;
    int           random_count;
    int           press_pct;
    int           drain;
    int           i;

    errors          = 0;
    words_sent      = 0;
    reports_checked = 0;
    dropped_presses = 0;
    repeat_presses  = 0;
    stray_releases  = 0;
    quiet           = 1'b0;
    held_mods       = 8'h00;
    for (i = 0; i < SLOTS; i++) key_slots[i] = EMPTY_CODE;
    none = make_report(8'h00, EMPTY_CODE, EMPTY_CODE, EMPTY_CODE, EMPTY_CODE, EMPTY_CODE,
                       EMPTY_CODE);

    plan = '{
      '{OP_PRESS,   16'h0000, 1'b1, none},
      '{OP_PRESS,   16'h8000, 1'b1, none},
      '{OP_PRESS,   16'h80FF, 1'b1, make_report(8'hFF, EMPTY_CODE, EMPTY_CODE, EMPTY_CODE,
                                                EMPTY_CODE, EMPTY_CODE, EMPTY_CODE)},
      '{OP_RELEASE, 16'h80FF, 1'b1, none},
      '{OP_PRESS,   16'h4000, 1'b1, none},
      '{OP_PRESS,   16'h40FF, 1'b1, make_report(8'h00, 8'hFF, EMPTY_CODE, EMPTY_CODE,
                                                EMPTY_CODE, EMPTY_CODE, EMPTY_CODE)},
      '{OP_PRESS,   16'h40FF, 1'b1, make_report(8'h00, 8'hFF, EMPTY_CODE, EMPTY_CODE,
                                                EMPTY_CODE, EMPTY_CODE, EMPTY_CODE)},
      '{OP_PRESS,   16'h4001, 1'b0, none},
      '{OP_PRESS,   16'h4002, 1'b0, none},
      '{OP_PRESS,   16'h4003, 1'b0, none},
      '{OP_PRESS,   16'h4004, 1'b0, none},
      '{OP_PRESS,   16'h4005, 1'b0, none},
      '{OP_PRESS,   16'h4006, 1'b0, none},   // all slots taken, dropped
      '{OP_RELEASE, 16'h4003, 1'b0, none},
      '{OP_PRESS,   16'h4080, 1'b0, none},   // refills the hole in the middle
      '{OP_RELEASE, 16'h4099, 1'b0, none},
      '{OP_RELEASE, 16'h4000, 1'b0, none},
      '{OP_PRESS,   16'hFFFF, 1'b0, none},
      '{OP_PRESS,   16'hC140, 1'b0, none},
      '{OP_PRESS,   16'h8081, 1'b0, none},
      '{OP_RELEASE, 16'h8001, 1'b0, none},
      '{OP_PRESS,   16'h3F80, 1'b0, none},
      '{OP_RELEASE, 16'h40FF, 1'b0, none},
      '{OP_RELEASE, 16'h8000, 1'b0, none}
    };

    rst_ni             <= 1'b0;
    key_ch.valid       <= 1'b0;
    key_ch.op          <= OP_PRESS;
    key_ch.key_code    <= 16'h0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < NUM_ROWS; i++)
      send_word(plan[i].op, plan[i].code, plan[i].typed, plan[i].want);

    // press bias swings every hundred words so the slots fill up and drain
    random_count = 0;
    press_pct    = $urandom_range(0, 1) ? 70 : 35;
    while (random_count < RANDOM_WORDS) begin
      if (random_count % 100 == 99) press_pct = (press_pct == 70) ? 35 : 70;
      if (random_count >= RANDOM_WORDS - QUIET_TAIL) quiet = 1'b1;
      random_event(press_pct, op, code, counted);
      send_word(op, code, 1'b0, none);
      if (counted) random_count++;
    end
    key_ch.valid <= 1'b0;

    drain = 0;
    while (expected_reports.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SLOTS + 8) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $error("%0d report words never arrived", expected_reports.size());
      errors += expected_reports.size();
    end

    $display("run: %0d key words sent, %0d reports checked", words_sent, reports_checked);
    $display("run: %0d presses dropped on full slots, %0d repeat presses, %0d stray releases",
             dropped_presses, repeat_presses, stray_releases);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hkr_pkg.sv
rtl/hkr_if.sv
rtl/hkr_ctrl.sv
rtl/hkr_dp.sv
rtl/hid_keyboard_report_slots.sv
dv/testbench.sv
